>>> rtl/obbsat_pkg.sv
// Shared widths, constants and the queue word type for the box overlap test.
package obbsat_pkg;
  localparam int CoordW   = 21;
  localparam int AxisW    = 16;
  localparam int DiffW    = 22;
  localparam int PrRW     = 32;
  localparam int PrTW     = 38;
  localparam int RW       = 34;
  localparam int FrW      = 35;
  localparam int TW       = 40;
  localparam int TLoW     = 20;
  localparam int THiW     = TW - TLoW;
  localparam int PeW      = 56;
  localparam int SumW     = 58;
  localparam int TrW      = 74;
  localparam int CmpW     = 100;
  localparam int BiasW    = 8;
  localparam int QDepth   = 2;
  localparam logic [BiasW-1:0] BiasReset = 8'd1;

  typedef struct packed {
    logic [2:0][TW-1:0]     t;
    logic [8:0][RW-1:0]     r;
    logic [8:0][FrW-1:0]    fr;
    logic [2:0][CoordW-1:0] ea;
    logic [2:0][CoordW-1:0] eb;
  } entry_t;
endpackage

>>> rtl/obbsat_front.sv
// Front end: unpack a box pair, form the relative rotation and the offset in A's frame.
module obbsat_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [62:0]                    center_a,
  input  logic [62:0]                    center_b,
  input  logic [62:0]                    half_extents_a,
  input  logic [62:0]                    half_extents_b,
  input  logic [47:0]                    axis_a_row0,
  input  logic [47:0]                    axis_a_row1,
  input  logic [47:0]                    axis_a_row2,
  input  logic [47:0]                    axis_b_row0,
  input  logic [47:0]                    axis_b_row1,
  input  logic [47:0]                    axis_b_row2,
  input  logic [obbsat_pkg::BiasW-1:0]   bias,
  input  logic                           q_full,
  output logic                           busy,
  output logic                           push,
  output obbsat_pkg::entry_t             entry
);
  logic adv;
  logic f1_valid, f2_valid, f3_valid;
  logic signed [obbsat_pkg::CoordW-1:0] ca [3];
  logic signed [obbsat_pkg::CoordW-1:0] cb [3];
  logic        [obbsat_pkg::CoordW-1:0] ea1 [3];
  logic        [obbsat_pkg::CoordW-1:0] eb1 [3];
  logic        [obbsat_pkg::CoordW-1:0] ea2 [3];
  logic        [obbsat_pkg::CoordW-1:0] eb2 [3];
  logic signed [obbsat_pkg::AxisW-1:0]  ax [3][3];
  logic signed [obbsat_pkg::AxisW-1:0]  bx [3][3];
  logic signed [obbsat_pkg::DiffW-1:0]  diff [3];
  logic signed [obbsat_pkg::PrRW-1:0]   pab [3][3][3];
  logic signed [obbsat_pkg::PrTW-1:0]   ptd [3][3];
  logic signed [obbsat_pkg::RW-1:0]     r_sum [3][3];
  logic        [obbsat_pkg::RW-1:0]     r_mag [3][3];
  logic signed [obbsat_pkg::TW-1:0]     t_sum [3];
  logic [47:0] arow [3];
  logic [47:0] brow [3];

  assign adv  = !f3_valid || !q_full;
  assign busy = !adv;
  assign push = f3_valid && adv;
  assign arow[0] = axis_a_row0;
  assign arow[1] = axis_a_row1;
  assign arow[2] = axis_a_row2;
  assign brow[0] = axis_b_row0;
  assign brow[1] = axis_b_row1;
  assign brow[2] = axis_b_row2;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= start;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = obbsat_pkg::DiffW'(cb[k]) - obbsat_pkg::DiffW'(ca[k]);
    end
    for (int i = 0; i < 3; i++) begin
      t_sum[i] = obbsat_pkg::TW'(ptd[i][0]) + obbsat_pkg::TW'(ptd[i][1])
               + obbsat_pkg::TW'(ptd[i][2]);
      for (int j = 0; j < 3; j++) begin
        r_sum[i][j] = obbsat_pkg::RW'(pab[i][j][0]) + obbsat_pkg::RW'(pab[i][j][1])
                    + obbsat_pkg::RW'(pab[i][j][2]);
        r_mag[i][j] = r_sum[i][j][obbsat_pkg::RW-1] ? obbsat_pkg::RW'(-r_sum[i][j])
                                                     : obbsat_pkg::RW'(r_sum[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ca[k]  <= center_a[k*obbsat_pkg::CoordW +: obbsat_pkg::CoordW];
        cb[k]  <= center_b[k*obbsat_pkg::CoordW +: obbsat_pkg::CoordW];
        ea1[k] <= half_extents_a[k*obbsat_pkg::CoordW +: obbsat_pkg::CoordW];
        eb1[k] <= half_extents_b[k*obbsat_pkg::CoordW +: obbsat_pkg::CoordW];
        ea2[k] <= ea1[k];
        eb2[k] <= eb1[k];
        entry.ea[k] <= ea2[k];
        entry.eb[k] <= eb2[k];
      end
      for (int i = 0; i < 3; i++) begin
        entry.t[i] <= t_sum[i];
        for (int k = 0; k < 3; k++) begin
          ax[i][k]  <= arow[i][k*obbsat_pkg::AxisW +: obbsat_pkg::AxisW];
          bx[i][k]  <= brow[i][k*obbsat_pkg::AxisW +: obbsat_pkg::AxisW];
          ptd[i][k] <= diff[k] * ax[i][k];
        end
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            pab[i][j][k] <= ax[i][k] * bx[j][k];
          end
          entry.r[i*3+j]  <= r_sum[i][j];
          entry.fr[i*3+j] <= obbsat_pkg::FrW'(r_mag[i][j])
                           + obbsat_pkg::FrW'({bias, 14'd0});
        end
      end
    end
  end
endmodule

>>> rtl/obbsat_queue.sv
// Short word queue between front and back ends.
module obbsat_queue #(
  parameter int DEPTH = obbsat_pkg::QDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  obbsat_pkg::entry_t wdata,
  output logic               full,
  output logic               head_valid,
  output obbsat_pkg::entry_t head
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  obbsat_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign pop        = head_valid;
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end
endmodule

>>> rtl/obbsat_back.sv
// Back end: evaluate the fifteen separating axes and reduce to one flag.
module obbsat_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  obbsat_pkg::entry_t e,
  output logic               done,
  output logic               boxes_overlap
);
  logic b1_valid, b2_valid, b3_valid;
  logic [obbsat_pkg::PeW-1:0] pe [3][9];
  logic [obbsat_pkg::PeW-1:0] pf [3][9];
  logic signed [54:0] ptl [3][9];
  logic signed [53:0] pth [3][9];
  logic [obbsat_pkg::TW-1:0]     t1 [3];
  logic [obbsat_pkg::CoordW-1:0] ea1 [3], eb1 [3], ea2 [3], eb2 [3];
  logic [obbsat_pkg::TW-1:0]     tmag2 [3];
  logic signed [obbsat_pkg::TrW-1:0] tr [3][9];
  logic [obbsat_pkg::SumW-1:0] rba [3], rab [3], rae [9], rbe [9];
  logic [14:0] sep;
  logic signed [obbsat_pkg::TrW+1:0] tb, te;
  logic [obbsat_pkg::TrW+1:0] tbm, tem;
  logic [14:0] sep_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      b1_valid <= in_valid;
      b2_valid <= b1_valid;
      b3_valid <= b2_valid;
      done     <= b3_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t1[i]  <= e.t[i];
      ea1[i] <= e.ea[i];
      eb1[i] <= e.eb[i];
      ea2[i] <= ea1[i];
      eb2[i] <= eb1[i];
      tmag2[i] <= t1[i][obbsat_pkg::TW-1] ? obbsat_pkg::TW'(-$signed(t1[i])) : t1[i];
      for (int m = 0; m < 9; m++) begin
        pe[i][m]  <= e.ea[i] * e.fr[m];
        pf[i][m]  <= e.eb[i] * e.fr[m];
        ptl[i][m] <= $signed({1'b0, e.t[i][obbsat_pkg::TLoW-1:0]}) * $signed(e.r[m]);
        pth[i][m] <= $signed(e.t[i][obbsat_pkg::TW-1:obbsat_pkg::TLoW]) * $signed(e.r[m]);
        tr[i][m]  <= (obbsat_pkg::TrW'(pth[i][m]) <<< obbsat_pkg::TLoW)
                   + obbsat_pkg::TrW'(ptl[i][m]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      rba[i] <= obbsat_pkg::SumW'(pf[0][i*3]) + obbsat_pkg::SumW'(pf[1][i*3+1])
              + obbsat_pkg::SumW'(pf[2][i*3+2]);
      rab[i] <= obbsat_pkg::SumW'(pe[0][i]) + obbsat_pkg::SumW'(pe[1][3+i])
              + obbsat_pkg::SumW'(pe[2][6+i]);
      for (int j = 0; j < 3; j++) begin
        rae[i*3+j] <= obbsat_pkg::SumW'(pe[(i+1)%3][((i+2)%3)*3+j])
                    + obbsat_pkg::SumW'(pe[(i+2)%3][((i+1)%3)*3+j]);
        rbe[i*3+j] <= obbsat_pkg::SumW'(pf[(j+1)%3][i*3+(j+2)%3])
                    + obbsat_pkg::SumW'(pf[(j+2)%3][i*3+(j+1)%3]);
      end
    end
    sep <= sep_c;
  end

  always_comb begin
    tb  = '0;
    te  = '0;
    tbm = '0;
    tem = '0;
    for (int i = 0; i < 3; i++) begin
      sep_c[i] = (obbsat_pkg::CmpW'(tmag2[i]) << 28) >
                 ((obbsat_pkg::CmpW'(ea2[i]) << 42) + (obbsat_pkg::CmpW'(rba[i]) << 14));
    end
    for (int j = 0; j < 3; j++) begin
      tb = (obbsat_pkg::TrW+2)'(tr[0][j]) + (obbsat_pkg::TrW+2)'(tr[1][3+j])
         + (obbsat_pkg::TrW+2)'(tr[2][6+j]);
      tbm = tb[obbsat_pkg::TrW+1] ? (obbsat_pkg::TrW+2)'(-tb) : (obbsat_pkg::TrW+2)'(tb);
      sep_c[3+j] = obbsat_pkg::CmpW'(tbm) >
                   ((obbsat_pkg::CmpW'(rab[j]) << 14) + (obbsat_pkg::CmpW'(eb2[j]) << 42));
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        te = (obbsat_pkg::TrW+2)'(tr[(i+2)%3][((i+1)%3)*3+j])
           - (obbsat_pkg::TrW+2)'(tr[(i+1)%3][((i+2)%3)*3+j]);
        tem = te[obbsat_pkg::TrW+1] ? (obbsat_pkg::TrW+2)'(-te) : (obbsat_pkg::TrW+2)'(te);
        sep_c[6+i*3+j] = obbsat_pkg::CmpW'(tem) >
                         ((obbsat_pkg::CmpW'(rae[i*3+j]) + obbsat_pkg::CmpW'(rbe[i*3+j])) << 14);
      end
    end
  end

  always_ff @(posedge clk) begin
    boxes_overlap <= ~|sep;
  end
endmodule

>>> rtl/obb_obb_separating_axis_test_core.sv
// Top level of the oriented box overlap test.
// Throughput: one box pair per cycle unless busy, set by front pipeline and queue pop.
// busy rises only on a full queue; the back end pops any stored word and never stalls.
// rst (synchronous) empties all pipelines and the queue and sets the bias to 1.
module obb_obb_separating_axis_test_core #(
  parameter int QUEUE_DEPTH = obbsat_pkg::QDepth
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [62:0]                  center_a,
  input  logic [62:0]                  center_b,
  input  logic [62:0]                  half_extents_a,
  input  logic [62:0]                  half_extents_b,
  input  logic [47:0]                  axis_a_row0,
  input  logic [47:0]                  axis_a_row1,
  input  logic [47:0]                  axis_a_row2,
  input  logic [47:0]                  axis_b_row0,
  input  logic [47:0]                  axis_b_row1,
  input  logic [47:0]                  axis_b_row2,
  input  logic                         bias_we,
  input  logic [obbsat_pkg::BiasW-1:0] bias_wdata,
  output logic                         done,
  output logic                         boxes_overlap
);
  logic [obbsat_pkg::BiasW-1:0] abs_rotation_bias;
  logic               push, q_full, head_valid;
  obbsat_pkg::entry_t fe_word, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_rotation_bias <= obbsat_pkg::BiasReset;
    end else if (bias_we) begin
      abs_rotation_bias <= bias_wdata;
    end
  end

  obbsat_front u_front (
    .clk, .rst, .start,
    .center_a, .center_b, .half_extents_a, .half_extents_b,
    .axis_a_row0, .axis_a_row1, .axis_a_row2,
    .axis_b_row0, .axis_b_row1, .axis_b_row2,
    .bias(abs_rotation_bias), .q_full, .busy, .push, .entry(fe_word)
  );

  obbsat_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .wdata(fe_word), .full(q_full), .head_valid, .head
  );

  obbsat_back u_back (
    .clk, .rst, .in_valid(head_valid), .e(head), .done, .boxes_overlap
  );
endmodule

>>> rtl/obbsat_checker.sv
// Port-level checks on the box overlap test, bound to the top level.
module obbsat_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##8 done) else $error("accepted word produced no result");
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, 8)) else $error("result without accepted word");
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done) else $error("result straight after reset");
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy) else $error("front end stalled");
endmodule

bind obb_obb_separating_axis_test_core obbsat_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
